// File: rtl/nfrbp_pkg.sv
// ----------------------------------------------------------------------------
// nfrbp_pkg
// Shared widths, register indexes and sequencer states for the next-fit
// risk-adjusted bin packer.
// ----------------------------------------------------------------------------
package nfrbp_pkg;

    localparam int ITEM_BITS_DEF      = 16;
    localparam int BIN_INDEX_BITS_DEF = 16;

    localparam int CAP_W  = 24;
    localparam int RISK_W = 16;
    localparam int TOL_W  = 8;
    localparam int LIM_W  = 25;
    localparam int MEAN_W = 26;
    localparam int LOAD_W = 26;
    localparam int VAR_W  = 32;
    localparam int ROOT_W = 16;
    localparam int PROD_W = RISK_W + ROOT_W;
    localparam int FRAC_W = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISK_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd2;

    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
    localparam logic [VAR_W-1:0]  VAR_MAX  = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT_GO,
        S_SQRT_RUN,
        S_MUL_J,
        S_MUL_A,
        S_ADD_A,
        S_DECIDE
    } t_state;

endpackage

// File: rtl/nfrbp_isqrt.sv
// ----------------------------------------------------------------------------
// nfrbp_isqrt
// Bit-serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nfrbp_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nfrbp_pkg::VAR_W-1:0]  i_radicand,
    output logic                        o_busy,
    output logic [nfrbp_pkg::ROOT_W-1:0] o_root
);

    localparam int RW    = nfrbp_pkg::ROOT_W;
    localparam int XW    = nfrbp_pkg::VAR_W;
    localparam int CNT_W = $clog2(RW);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [XW-1:0]    r_x;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;

    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          take;

    // Bring down the next two radicand bits and try appending a one.
    always_comb begin
        rem_sh = {r_rem, r_x[XW-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[XW-3:0], 2'b00};
            r_rem  <= take ? diff[RW+1:0] : rem_sh[RW+1:0];
            r_root <= {r_root[RW-2:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// File: rtl/next_fit_risk_bin_packer.sv
// ----------------------------------------------------------------------------
// next_fit_risk_bin_packer
// An accepted item runs through the two 16-step bit-serial square root units,
// then two passes through the one shared 16x16 multiplier and the fit decision.
// A new item is taken only once the current one has been decided and its
// result written to the output register.
// Reset (synchronous, active low) clears the configuration registers to zero,
// the bin index and sums to zero, and marks the current bin empty and open.
// ----------------------------------------------------------------------------
module next_fit_risk_bin_packer #(
    parameter int ITEM_BITS      = nfrbp_pkg::ITEM_BITS_DEF,
    parameter int BIN_INDEX_BITS = nfrbp_pkg::BIN_INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ITEM_BITS-1:0]             i_mean_size,
    input  logic [ITEM_BITS-1:0]             i_variance,
    input  logic                             i_start_run,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [BIN_INDEX_BITS-1:0]        o_bin_index,
    output logic                             o_opened_new,
    output logic                             o_oversize,
    output logic [nfrbp_pkg::LOAD_W-1:0]     o_bin_load,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nfrbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nfrbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MEAN_W = nfrbp_pkg::MEAN_W;
    localparam int VAR_W  = nfrbp_pkg::VAR_W;
    localparam int LOAD_W = nfrbp_pkg::LOAD_W;
    localparam int LIM_W  = nfrbp_pkg::LIM_W;
    localparam int ROOT_W = nfrbp_pkg::ROOT_W;
    localparam int PROD_W = nfrbp_pkg::PROD_W;
    localparam int FRAC_W = nfrbp_pkg::FRAC_W;
    // Adder width for the mean sum: wide enough for either operand plus carry.
    localparam int MSUM_W = ((ITEM_BITS > MEAN_W) ? ITEM_BITS : MEAN_W) + 1;

    // Configuration registers. The port is always ready; writes must arrive only
    // while the packer is idle, which the block itself does not enforce.
    logic [nfrbp_pkg::CAP_W-1:0]  r_capacity;
    logic [nfrbp_pkg::RISK_W-1:0] r_risk;
    logic [nfrbp_pkg::TOL_W-1:0]  r_tolerance;
    logic [LIM_W-1:0]             r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_risk      <= '0;
            r_tolerance <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nfrbp_pkg::REG_CAPACITY:    r_capacity  <= i_cfg_data;
                nfrbp_pkg::REG_RISK_FACTOR: r_risk      <= i_cfg_data[nfrbp_pkg::RISK_W-1:0];
                nfrbp_pkg::REG_TOLERANCE:   r_tolerance <= i_cfg_data[nfrbp_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // The fit limit is kept precomputed in a register from the capacity and
    // tolerance registers, long before any accepted item reaches the decision.
    always_ff @(posedge i_clk) begin
        r_limit <= LIM_W'(r_capacity) + LIM_W'(r_tolerance);
    end

    // Sequencer.
    nfrbp_pkg::t_state r_state, n_state;

    logic in_fire;
    logic out_fire;
    logic sqrt_go;
    logic mul_alone;
    logic decide_fire;
    logic sqrt_busy_j, sqrt_busy_a;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = o_out_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nfrbp_pkg::S_IDLE:     if (i_in_valid) n_state = nfrbp_pkg::S_SQRT_GO;
            nfrbp_pkg::S_SQRT_GO:  n_state = nfrbp_pkg::S_SQRT_RUN;
            nfrbp_pkg::S_SQRT_RUN: if (!sqrt_busy_j) n_state = nfrbp_pkg::S_MUL_J;
            nfrbp_pkg::S_MUL_J:    n_state = nfrbp_pkg::S_MUL_A;
            nfrbp_pkg::S_MUL_A:    n_state = nfrbp_pkg::S_ADD_A;
            nfrbp_pkg::S_ADD_A:    n_state = nfrbp_pkg::S_DECIDE;
            nfrbp_pkg::S_DECIDE: begin
                if (!o_out_valid || !i_out_stall) n_state = nfrbp_pkg::S_IDLE;
            end
            default:               n_state = nfrbp_pkg::S_IDLE;
        endcase
    end

    // The decision waits only while the output register is occupied and stalled.
    always_comb begin
        o_in_stall  = (r_state != nfrbp_pkg::S_IDLE);
        sqrt_go     = (r_state == nfrbp_pkg::S_SQRT_GO);
        mul_alone   = (r_state == nfrbp_pkg::S_MUL_A);
        decide_fire = (r_state == nfrbp_pkg::S_DECIDE) && (!o_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfrbp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Bin state.
    logic [MEAN_W-1:0]         r_mean_sum;
    logic [VAR_W-1:0]          r_var_sum;
    logic [BIN_INDEX_BITS-1:0] r_cur_bin;
    logic                      r_bin_empty;
    logic                      r_bin_closed;
    logic                      r_opened;

    // Candidate sums: joined to the current bin, and the item alone.
    logic [MEAN_W-1:0] r_na_j, r_na_a;
    logic [VAR_W-1:0]  r_nb_j, r_nb_a;

    logic [BIN_INDEX_BITS-1:0] bin_inc;
    logic                      fresh;
    logic [MEAN_W-1:0]         mean_eff;
    logic [VAR_W-1:0]          var_eff;
    logic [MSUM_W-1:0]         msum_j;
    logic [MSUM_W-1:0]         msum_a;
    logic [VAR_W:0]            vsum_j;

    // The bin index saturates at its top value; opening a bin there keeps it.
    assign bin_inc = (r_cur_bin == {BIN_INDEX_BITS{1'b1}}) ? r_cur_bin
                                                          : r_cur_bin + 1'b1;

    // A run start or a bin closed by an oversize item empties the sums before
    // the new item is tried.
    always_comb begin
        fresh    = i_start_run || r_bin_closed;
        mean_eff = fresh ? '0 : r_mean_sum;
        var_eff  = fresh ? '0 : r_var_sum;
        msum_j   = MSUM_W'(mean_eff) + MSUM_W'(i_mean_size);
        msum_a   = MSUM_W'(i_mean_size);
        vsum_j   = (VAR_W + 1)'(var_eff) + (VAR_W + 1)'(i_variance);
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_na_j <= (msum_j > MSUM_W'(nfrbp_pkg::MEAN_MAX)) ? nfrbp_pkg::MEAN_MAX
                                                              : msum_j[MEAN_W-1:0];
            r_na_a <= (msum_a > MSUM_W'(nfrbp_pkg::MEAN_MAX)) ? nfrbp_pkg::MEAN_MAX
                                                              : msum_a[MEAN_W-1:0];
            r_nb_j <= vsum_j[VAR_W] ? nfrbp_pkg::VAR_MAX : vsum_j[VAR_W-1:0];
            r_nb_a <= VAR_W'(i_variance);
        end
    end

    // Two square root units run side by side: one for the joined variance,
    // one for the item's own variance in case it has to start a new bin.
    logic [ROOT_W-1:0] root_j, root_a;

    nfrbp_isqrt u_sqrt_j (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_go),
        .i_radicand (r_nb_j),
        .o_busy     (sqrt_busy_j),
        .o_root     (root_j)
    );

    nfrbp_isqrt u_sqrt_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_go),
        .i_radicand (r_nb_a),
        .o_busy     (sqrt_busy_a),
        .o_root     (root_a)
    );

    // One shared multiplier serves both roots on consecutive cycles. Its Q24.8
    // product of risk (Q8.8) and root is truncated, added to the mean sum, saturating.
    logic [PROD_W-1:0] r_prod;
    logic [LOAD_W-1:0] r_load_j, r_load_a;
    logic [LOAD_W:0]   load_sum;
    logic [LOAD_W-1:0] load_sat;

    always_comb begin
        load_sum = (LOAD_W + 1)'(mul_alone ? r_na_j : r_na_a)
                 + (LOAD_W + 1)'(r_prod[PROD_W-1:FRAC_W]);
        load_sat = load_sum[LOAD_W] ? nfrbp_pkg::LOAD_MAX : load_sum[LOAD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_risk * (mul_alone ? root_a : root_j);
        if (r_state == nfrbp_pkg::S_MUL_A) begin
            r_load_j <= load_sat;
        end
        if (r_state == nfrbp_pkg::S_ADD_A) begin
            r_load_a <= load_sat;
        end
    end

    // Fit decision. If the joined load is too high and the bin already holds
    // something, the next bin opens and the item's own figures are used.
    logic              move_on;
    logic [LOAD_W-1:0] load_sel;
    logic              over;

    always_comb begin
        move_on  = (r_load_j > LOAD_W'(r_limit)) && !r_bin_empty;
        load_sel = move_on ? r_load_a : r_load_j;
        over     = (load_sel > LOAD_W'(r_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_sum   <= '0;
            r_var_sum    <= '0;
            r_cur_bin    <= '0;
            r_bin_empty  <= 1'b1;
            r_bin_closed <= 1'b0;
            r_opened     <= 1'b0;
        end else if (in_fire) begin
            // A run start restarts at bin zero; otherwise a closed bin is left.
            if (i_start_run) begin
                r_cur_bin <= '0;
            end else if (r_bin_closed) begin
                r_cur_bin <= bin_inc;
            end
            r_opened     <= !i_start_run && r_bin_closed;
            r_bin_empty  <= fresh ? 1'b1 : r_bin_empty;
            r_bin_closed <= 1'b0;
        end else if (decide_fire) begin
            if (move_on) begin
                r_cur_bin <= bin_inc;
            end
            r_mean_sum   <= move_on ? r_na_a : r_na_j;
            r_var_sum    <= move_on ? r_nb_a : r_nb_j;
            r_bin_empty  <= 1'b0;
            r_bin_closed <= over;
        end
    end

    // Output register: holds a finished item until the consumer takes it.
    logic                      r_out_valid;
    logic [BIN_INDEX_BITS-1:0] r_out_bin;
    logic                      r_out_opened;
    logic                      r_out_over;
    logic [LOAD_W-1:0]         r_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (decide_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decide_fire) begin
            r_out_bin    <= move_on ? bin_inc : r_cur_bin;
            r_out_opened <= r_opened || move_on;
            r_out_over   <= over;
            r_out_load   <= load_sel;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_index  = r_out_bin;
    assign o_opened_new = r_out_opened;
    assign o_oversize   = r_out_over;
    assign o_bin_load   = r_out_load;

    // Both root units are started together and must finish together.
    a_sqrt_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_busy_j == sqrt_busy_a)
        else $error("square root units out of step");

    // No root computation may be in flight while the packer is idle.
    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfrbp_pkg::S_IDLE) |-> !sqrt_busy_j)
        else $error("square root busy while idle");

    // A closed bin always holds its oversize item.
    a_closed_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin_closed |-> !r_bin_empty)
        else $error("closed bin marked empty");

    // A decision always lands a result in the output register.
    a_decide_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        decide_fire |=> (o_out_valid && (r_state == nfrbp_pkg::S_IDLE)))
        else $error("decision did not produce a result");

endmodule
